>>> hdl/mwm_pkg.sv
// Shared constants and stage types for the mecanum wheel mixer.
`timescale 1ns / 1ps

package mwm_pkg;

    // Fixed-point scaling: 1.0 == 2**FRAC_BITS.
    localparam int unsigned FRAC_BITS = 14;
    localparam int unsigned ONE       = 32'd1 << FRAC_BITS;

    localparam int unsigned CMD_W     = 16;
    localparam int unsigned SEL_W     = 2;
    localparam int unsigned PWM_W     = 16;
    localparam int unsigned NUM_WHEEL = 4;

    // Sum of three commands, its magnitude, and the restoring remainder (< 2 * max).
    localparam int unsigned SUM_W = CMD_W + 2;
    localparam int unsigned MAG_W = SUM_W - 1;
    localparam int unsigned REM_W = MAG_W + 1;

    // Quotient |s| * ONE / max never exceeds ONE, so FRAC_BITS + 1 bits.
    localparam int unsigned QW            = FRAC_BITS + 1;
    localparam int unsigned STEPS_PER_STG = 3;
    localparam int unsigned DIV_STG       = (QW + STEPS_PER_STG - 1) / STEPS_PER_STG;

    // Sum, magnitude, max, divider stages, output register.
    localparam int unsigned NSTG = DIV_STG + 4;

    // Wheel lanes.
    localparam int unsigned LF = 0;
    localparam int unsigned LR = 1;
    localparam int unsigned RF = 2;
    localparam int unsigned RR = 3;

    typedef enum logic [SEL_W-1:0] {
        WS_ALL   = 2'd0,
        WS_REAR  = 2'd1,
        WS_FRONT = 2'd2,
        WS_NONE  = 2'd3
    } t_wheel_set;

    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic        [MAG_W-1:0] t_mag;

    typedef struct {
        t_sum             sum [NUM_WHEEL];
        logic [SEL_W-1:0] sel;
    } t_s1;

    typedef struct {
        t_sum             sum [NUM_WHEEL];
        t_mag             mag [NUM_WHEEL];
        t_mag             m01;
        t_mag             m23;
        logic [SEL_W-1:0] sel;
    } t_s2;

    typedef struct {
        t_sum             sum;
        logic [REM_W-1:0] rem;
        logic [QW-1:0]    quo;
    } t_lane;

    typedef struct {
        t_lane            lane [NUM_WHEEL];
        t_mag             mmax;
        logic             big;
        logic [SEL_W-1:0] sel;
    } t_ditem;

endpackage

>>> hdl/mecanum_wheel_mixer.sv
// Mecanum wheel mixer: four wheel sums normalized by the largest magnitude when it exceeds 1.0.
//
// Input channel: i_valid / o_stall with drive, strafe, rotate commands
// (signed, 1.0 = 2**FRAC_BITS) and a wheel-set code. A beat is taken on a
// rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with four signed motor commands; a beat
// leaves on a rising edge with o_valid high and i_stall low.
// Stages: wheel sums, magnitudes and pairwise max, overall max, then
// the restoring divider at three quotient bits per stage, then the output
// register. Four divider lanes run side by side.
// Throughput: one beat per cycle while the output is not held.
// Stall: each stage holds its beat while the stage after it is full and
// held; empty stages keep filling, so o_stall only rises once every stage
// is occupied and the output is held.
// Reset (synchronous, active low) clears all valid bits; nothing else is
// carried from one beat to the next.
`timescale 1ns / 1ps

module mecanum_wheel_mixer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [mwm_pkg::CMD_W-1:0]    i_drive_cmd,
    input  logic signed [mwm_pkg::CMD_W-1:0]    i_strafe_cmd,
    input  logic signed [mwm_pkg::CMD_W-1:0]    i_rotate_cmd,
    input  logic        [mwm_pkg::SEL_W-1:0]    i_wheel_set,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [mwm_pkg::PWM_W-1:0]    o_left_front_pwm,
    output logic signed [mwm_pkg::PWM_W-1:0]    o_left_rear_pwm,
    output logic signed [mwm_pkg::PWM_W-1:0]    o_right_front_pwm,
    output logic signed [mwm_pkg::PWM_W-1:0]    o_right_rear_pwm
);
    import mwm_pkg::*;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] en;

    t_s1    r_s1, n_s1;
    t_s2    r_s2, n_s2;
    t_ditem r_s3, n_s3;
    t_ditem r_div [DIV_STG];
    t_ditem n_div [DIV_STG];
    t_ditem w_src [DIV_STG];

    logic signed [PWM_W-1:0] r_pwm [NUM_WHEEL];
    logic signed [PWM_W-1:0] n_pwm [NUM_WHEEL];

    // A stage may load when it is empty or its contents move on.
    always_comb begin
        en[NSTG-1] = !r_v[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: wheel sums.
    always_comb begin
        t_sum d;
        t_sum s;
        t_sum r;
        d = SUM_W'(i_drive_cmd);
        s = SUM_W'(i_strafe_cmd);
        r = SUM_W'(i_rotate_cmd);
        n_s1.sum[LF] = r + d + s;
        n_s1.sum[LR] = r + d - s;
        n_s1.sum[RF] = r - d + s;
        n_s1.sum[RR] = r - d - s;
        n_s1.sel     = i_wheel_set;
    end

    // Stage 2: magnitudes and pairwise max.
    always_comb begin
        t_sum neg;
        n_s2.sum = r_s1.sum;
        n_s2.sel = r_s1.sel;
        for (int w = 0; w < NUM_WHEEL; w++) begin
            neg = -r_s1.sum[w];
            n_s2.mag[w] = r_s1.sum[w][SUM_W-1] ? neg[MAG_W-1:0] : r_s1.sum[w][MAG_W-1:0];
        end
        n_s2.m01 = (n_s2.mag[LF] > n_s2.mag[LR]) ? n_s2.mag[LF] : n_s2.mag[LR];
        n_s2.m23 = (n_s2.mag[RF] > n_s2.mag[RR]) ? n_s2.mag[RF] : n_s2.mag[RR];
    end

    // Stage 3: overall max, normalize flag, divider seed.
    always_comb begin
        n_s3.mmax = (r_s2.m01 > r_s2.m23) ? r_s2.m01 : r_s2.m23;
        n_s3.big  = 32'(n_s3.mmax) > 32'(ONE);
        n_s3.sel  = r_s2.sel;
        for (int w = 0; w < NUM_WHEEL; w++) begin
            n_s3.lane[w].sum = r_s2.sum[w];
            n_s3.lane[w].rem = REM_W'(r_s2.mag[w]);
            n_s3.lane[w].quo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1 <= n_s1;
        end
        if (en[1]) begin
            r_s2 <= n_s2;
        end
        if (en[2]) begin
            r_s3 <= n_s3;
        end
    end

    // Restoring division |s| * ONE / max; remainder stays below max.
    // The first step compares without shifting since |s| <= max.
    for (genvar d = 0; d < DIV_STG; d++) begin : g_div
        if (d == 0) begin : g_first
            always_comb w_src[d] = r_s3;
        end else begin : g_next
            always_comb w_src[d] = r_div[d-1];
        end

        always_comb begin
            logic [REM_W-1:0] cand;
            logic [REM_W-1:0] den;
            logic             ge;
            n_div[d] = w_src[d];
            den      = REM_W'(w_src[d].mmax);
            for (int w = 0; w < NUM_WHEEL; w++) begin
                for (int t = 0; t < STEPS_PER_STG; t++) begin
                    if (d * STEPS_PER_STG + t < QW) begin
                        if (d * STEPS_PER_STG + t == 0) begin
                            cand = n_div[d].lane[w].rem;
                        end else begin
                            cand = {n_div[d].lane[w].rem[REM_W-2:0], 1'b0};
                        end
                        ge = cand >= den;
                        n_div[d].lane[w].rem = ge ? cand - den : cand;
                        n_div[d].lane[w].quo = {n_div[d].lane[w].quo[QW-2:0], ge};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[3+d]) begin
                r_div[d] <= n_div[d];
            end
        end
    end

    // Output stage: wheel select, sign restore, pass-through when max <= 1.0.
    always_comb begin
        t_ditem             src;
        logic               use_front;
        logic               use_rear;
        logic               sel_w;
        logic signed [QW:0] sq;
        src       = r_div[DIV_STG-1];
        use_front = (src.sel == WS_ALL) || (src.sel == WS_FRONT);
        use_rear  = (src.sel == WS_ALL) || (src.sel == WS_REAR);
        for (int w = 0; w < NUM_WHEEL; w++) begin
            sel_w = (w == LF || w == RF) ? use_front : use_rear;
            sq    = $signed({1'b0, src.lane[w].quo});
            if (src.lane[w].sum[SUM_W-1]) begin
                sq = -sq;
            end
            if (!sel_w) begin
                n_pwm[w] = '0;
            end else if (!src.big) begin
                n_pwm[w] = PWM_W'(src.lane[w].sum);
            end else begin
                n_pwm[w] = PWM_W'(sq);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NSTG-1]) begin
            r_pwm <= n_pwm;
        end
    end

    assign o_left_front_pwm  = r_pwm[LF];
    assign o_left_rear_pwm   = r_pwm[LR];
    assign o_right_front_pwm = r_pwm[RF];
    assign o_right_rear_pwm  = r_pwm[RR];

endmodule

>>> hdl/mwm_checker.sv
// Port-level checks for the mecanum wheel mixer, bound to the top level.
`timescale 1ns / 1ps

module mwm_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_stall,
    input  logic signed [mwm_pkg::CMD_W-1:0]    i_drive_cmd,
    input  logic signed [mwm_pkg::CMD_W-1:0]    i_strafe_cmd,
    input  logic signed [mwm_pkg::CMD_W-1:0]    i_rotate_cmd,
    input  logic        [mwm_pkg::SEL_W-1:0]    i_wheel_set,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  logic signed [mwm_pkg::PWM_W-1:0]    o_left_front_pwm,
    input  logic signed [mwm_pkg::PWM_W-1:0]    o_left_rear_pwm,
    input  logic signed [mwm_pkg::PWM_W-1:0]    o_right_front_pwm,
    input  logic signed [mwm_pkg::PWM_W-1:0]    o_right_rear_pwm
);
    import mwm_pkg::*;

    localparam logic signed [PWM_W-1:0] LIM = PWM_W'(ONE);

    // Pipeline empties on reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Input side only backs up once the output holds a beat.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output free");

    // A held output beat keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_left_front_pwm)
            && $stable(o_left_rear_pwm) && $stable(o_right_front_pwm)
            && $stable(o_right_rear_pwm))
        else $error("held output beat changed");

    // Normalized motor commands stay within +-1.0.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_left_front_pwm >= -LIM && o_left_front_pwm <= LIM
            && o_left_rear_pwm >= -LIM && o_left_rear_pwm <= LIM
            && o_right_front_pwm >= -LIM && o_right_front_pwm <= LIM
            && o_right_rear_pwm >= -LIM && o_right_rear_pwm <= LIM)
        else $error("motor command out of range");

endmodule

bind mecanum_wheel_mixer mwm_checker u_mwm_checker (.*);
